// ----- rtl/pwtw_pkg.sv -----
// Shared types, sizes and codes of the priority wait table waker.
package pwtw_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_SIGNAL    = 2'd2,
    OP_BROADCAST = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_NONE = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]        waiter;
    logic [7:0]        lock;
    logic signed [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

endpackage

// ----- rtl/pwtw_table.sv -----
// Entry store of the wait table: one write port and one registered read port.
module pwtw_table
  import pwtw_pkg::*;
(
  input  logic    clk_i,
  input  tbl_wr_t wr_i,
  input  tbl_rd_t rd_i,
  output entry_t  rd_data_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/priority_wait_table_waker_unit.sv -----
// Top level of the priority wait table waker: sequencer, scan compare unit and result register.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   operation, waiter_id, lock_id, priority_req
//   out      source     out_valid_o / out_stall_i wake_valid, wake_waiter_id, status, last
//
// An insert goes to the done state and loads its result once the result register is free.
// Remove, signal and broadcast walk the table one entry per cycle through the single read port
// of the entry store, unless a blocked broadcast match holds the scan.
// The block takes no new beat until the final result of the current one is loaded.
// A stall on the result side holds the scan only where a broadcast match must pass out
// an earlier match first; reset empties the table at once by clearing the entry count.
module priority_wait_table_waker_unit
  import pwtw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        waiter_id_i,
  input  logic [7:0]        lock_id_i,
  input  logic signed [7:0] priority_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              wake_valid_o,
  output logic [7:0]        wake_waiter_id_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  // Sequencer states.
  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_SCAN = 2'd1;
  localparam logic [1:0] SEQ_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;      // entries held; positions below it are valid
  logic [CNT_W-1:0]  rp_q, rp_d;        // next position to read
  logic [CNT_W-1:0]  keep_q, keep_d;    // compaction write position on remove
  logic              dv_q, dv_d;        // read data register holds an entry to look at
  logic              found_q, found_d;  // signal: a candidate has been seen
  logic              pend_v_q, pend_v_d; // broadcast: a match waits to be sent
  logic              ov_q, ov_d;

  // Latched request.
  op_e               op_q;
  logic [7:0]        waiter_q;
  logic [7:0]        lock_q;
  logic signed [7:0] prio_q;

  // Scan payload.
  logic signed [7:0] best_prio_q;
  logic [7:0]        best_id_q;
  logic [7:0]        pend_id_q;

  // Result register payload.
  logic              wake_valid_q, wake_valid_d;
  logic [7:0]        wake_id_q, wake_id_d;
  status_e           status_q, status_d;
  logic              last_q, last_d;
  logic              out_ld;

  tbl_wr_t           tbl_wr;
  tbl_rd_t           tbl_rd;
  entry_t            cur;

  logic              accept, out_free, lock_hit, bc_hit, better, blocked, step, scan_end;
  logic              consume, rd_go, rm_keep, bc_emit;

  pwtw_table u_table (
    .clk_i    (clk_i),
    .wr_i     (tbl_wr),
    .rd_i     (tbl_rd),
    .rd_data_o(cur)
  );

  assign in_stall_o = (state_q != SEQ_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  // The shared compare unit looks at one entry per cycle unless a blocked broadcast holds the scan.
  assign lock_hit = (cur.lock == lock_q);
  assign bc_hit   = lock_hit && ($signed(cur.prio) >= $signed(prio_q));
  assign better   = lock_hit && (!found_q || ($signed(cur.prio) > $signed(best_prio_q)));

  // A broadcast match with an earlier match waiting needs the result register.
  assign blocked  = dv_q && (op_q == OP_BROADCAST) && bc_hit && pend_v_q && !out_free;
  assign step     = (state_q == SEQ_SCAN) && !blocked;
  assign consume  = step && dv_q;
  assign rd_go    = step && (rp_q < cnt_q);
  assign scan_end = (state_q == SEQ_SCAN) && !dv_q && (rp_q == cnt_q);
  assign rm_keep  = consume && (op_q == OP_REMOVE) && (cur.waiter != waiter_q);
  assign bc_emit  = consume && (op_q == OP_BROADCAST) && bc_hit && pend_v_q;

  assign tbl_rd.en   = rd_go;
  assign tbl_rd.addr = rp_q[IDX_W-1:0];

  always_comb begin
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = keep_q[IDX_W-1:0];
    tbl_wr.data = cur;
    if (rm_keep) begin
      tbl_wr.en = 1'b1;
    end else if ((state_q == SEQ_DONE) && out_free && (op_q == OP_INSERT) &&
                 (cnt_q < CNT_W'(TABLE_DEPTH))) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = cnt_q[IDX_W-1:0];
      tbl_wr.data = '{waiter: waiter_q, lock: lock_q, prio: prio_q};
    end
  end

  // Result register loading.
  always_comb begin
    out_ld       = 1'b0;
    wake_valid_d = 1'b0;
    wake_id_d    = '0;
    status_d     = STATUS_OK;
    last_d       = 1'b1;
    if (bc_emit) begin
      out_ld       = 1'b1;
      wake_valid_d = 1'b1;
      wake_id_d    = pend_id_q;
      last_d       = 1'b0;
    end else if ((state_q == SEQ_DONE) && out_free) begin
      out_ld = 1'b1;
      case (op_q)
        OP_INSERT: begin
          status_d = (cnt_q < CNT_W'(TABLE_DEPTH)) ? STATUS_OK : STATUS_FULL;
        end
        OP_REMOVE: begin
          status_d = (keep_q < cnt_q) ? STATUS_OK : STATUS_NONE;
        end
        OP_SIGNAL: begin
          wake_valid_d = found_q;
          wake_id_d    = found_q ? best_id_q : '0;
          status_d     = found_q ? STATUS_OK : STATUS_NONE;
        end
        OP_BROADCAST: begin
          wake_valid_d = pend_v_q;
          wake_id_d    = pend_v_q ? pend_id_q : '0;
          status_d     = pend_v_q ? STATUS_OK : STATUS_NONE;
        end
        default: begin
          status_d = STATUS_NONE;
        end
      endcase
    end
  end

  assign ov_d = out_ld ? 1'b1 : (ov_q && out_stall_i);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rp_d     = rp_q;
    keep_d   = keep_q;
    dv_d     = dv_q;
    found_d  = found_q;
    pend_v_d = pend_v_q;
    case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          rp_d     = '0;
          keep_d   = '0;
          dv_d     = 1'b0;
          found_d  = 1'b0;
          pend_v_d = 1'b0;
          state_d  = (op_e'(operation_i) == OP_INSERT) ? SEQ_DONE : SEQ_SCAN;
        end
      end
      SEQ_SCAN: begin
        if (step) begin
          dv_d = rd_go;
          if (rd_go) begin
            rp_d = rp_q + CNT_W'(1);
          end
        end
        if (rm_keep) begin
          keep_d = keep_q + CNT_W'(1);
        end
        if (consume && (op_q == OP_SIGNAL) && better) begin
          found_d = 1'b1;
        end
        if (consume && (op_q == OP_BROADCAST) && bc_hit) begin
          pend_v_d = 1'b1;
        end
        if (scan_end) begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (out_free) begin
          state_d = SEQ_IDLE;
          if ((op_q == OP_INSERT) && (cnt_q < CNT_W'(TABLE_DEPTH))) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else if (op_q == OP_REMOVE) begin
            cnt_d = keep_q;
          end
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      cnt_q    <= '0;
      rp_q     <= '0;
      keep_q   <= '0;
      dv_q     <= 1'b0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rp_q     <= rp_d;
      keep_q   <= keep_d;
      dv_q     <= dv_d;
      found_q  <= found_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(operation_i);
      waiter_q <= waiter_id_i;
      lock_q   <= lock_id_i;
      prio_q   <= priority_req_i;
    end
    if (consume && (op_q == OP_SIGNAL) && better) begin
      best_prio_q <= cur.prio;
      best_id_q   <= cur.waiter;
    end
    if (consume && (op_q == OP_BROADCAST) && bc_hit) begin
      pend_id_q <= cur.waiter;
    end
    if (out_ld) begin
      wake_valid_q <= wake_valid_d;
      wake_id_q    <= wake_id_d;
      status_q     <= status_d;
      last_q       <= last_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign wake_valid_o     = wake_valid_q;
  assign wake_waiter_id_o = wake_id_q;
  assign status_o         = status_q;
  assign last_o           = last_q;

  // The entry count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table size");

  // The scan never reads beyond the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_SCAN) |-> (rp_q <= cnt_q))
    else $error("scan pointer beyond entry count");

  // Remove never compacts ahead of its read position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_SCAN) |-> (keep_q <= rp_q))
    else $error("compaction position ahead of scan");

  // Only the final beat of an item can carry no wake.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !wake_valid_q) |-> last_q)
    else $error("non-final result without a wake");

  // Read data never waits while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_IDLE) |-> !dv_q)
    else $error("stale table read in idle");

endmodule
